>>> rtl/core/multichannel_condition_interval_finder_assert.svh
// Assertion macros used by the checker file of the interval finder.
// Depends on nothing; include by bare file name.
`ifndef MULTICHANNEL_CONDITION_INTERVAL_FINDER_ASSERT_SVH
`define MULTICHANNEL_CONDITION_INTERVAL_FINDER_ASSERT_SVH

// Same-cycle implication, masked during reset.
`define MCIF_ASSERT_NOW(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mcif: same-cycle check failed");

// Next-cycle implication, masked during reset.
`define MCIF_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mcif: next-cycle check failed");

// Next-cycle implication that also holds across reset.
`define MCIF_ASSERT_ALWAYS_NEXT(name, clk, ante, cons) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("mcif: reset check failed");

`endif

>>> rtl/core/mcif_pkg.sv
// Shared types, constants and functions of the condition interval finder.
// No dependencies; used by every RTL module and interface through scoped names.
package mcif_pkg;

  localparam int CHANNELS = 16;
  localparam int STORE_N  = 16;
  localparam int NCH      = (CHANNELS < STORE_N) ? CHANNELS : STORE_N;
  localparam int CH_W     = 4;
  localparam int TIME_W   = 32;
  localparam int MODE_W   = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 3;

  localparam logic [STORE_N-1:0] CH_MASK = STORE_N'((17'd1 << NCH) - 17'd1);

  localparam logic [MODE_W-1:0] MODE_LT = 3'd0;
  localparam logic [MODE_W-1:0] MODE_LE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_EQ = 3'd2;
  localparam logic [MODE_W-1:0] MODE_NE = 3'd3;
  localparam logic [MODE_W-1:0] MODE_GT = 3'd4;
  localparam logic [MODE_W-1:0] MODE_GE = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_COMPARE_MODE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COMPARE_VALUE = 1'd1;

  localparam logic [MODE_W-1:0] MODE_RESET  = MODE_EQ;
  localparam logic              VALUE_RESET = 1'b1;

  typedef struct packed {
    logic load;
    logic step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic emit_here;
    logic scan_last;
    logic out_free;
  } stat_t;

  // Condition of every channel bit against the reference value.
  function automatic logic [STORE_N-1:0] cond_vec(input logic [MODE_W-1:0] mode,
                                                   input logic value,
                                                   input logic [STORE_N-1:0] bits);
    logic [STORE_N-1:0] v;
    v = {STORE_N{value}};
    case (mode)
      MODE_LT: cond_vec = ~bits & v;
      MODE_LE: cond_vec = ~bits | v;
      MODE_EQ: cond_vec = ~(bits ^ v);
      MODE_NE: cond_vec = bits ^ v;
      MODE_GT: cond_vec = bits & ~v;
      MODE_GE: cond_vec = bits | ~v;
      default: cond_vec = '0;
    endcase
  endfunction

endpackage

>>> rtl/core/mcif_in_if.sv
// Input channel of the interval finder: valid/ready with sample payload.
// Depends on mcif_pkg.
interface mcif_in_if;
  logic                          valid;
  logic                          ready;
  logic                          func;
  logic [mcif_pkg::TIME_W-1:0]   sample_time;
  logic [mcif_pkg::STORE_N-1:0]  channel_bits;

  modport source (output valid, output func, output sample_time, output channel_bits,
                  input ready);
  modport sink (input valid, input func, input sample_time, input channel_bits,
                output ready);
endinterface

>>> rtl/core/mcif_out_if.sv
// Output channel of the interval finder: valid/ready with interval payload.
// Depends on mcif_pkg.
interface mcif_out_if;
  logic                        valid;
  logic                        ready;
  logic [mcif_pkg::CH_W-1:0]   channel;
  logic [mcif_pkg::TIME_W-1:0] open_time;
  logic [mcif_pkg::TIME_W-1:0] close_time;
  logic                        last;

  modport source (output valid, output channel, output open_time, output close_time,
                  output last, input ready);
  modport sink (input valid, input channel, input open_time, input close_time,
                input last, output ready);
endinterface

>>> rtl/core/mcif_ctrl.sv
// Controller of the interval finder: accepts an item, then walks the channels.
// Depends on mcif_pkg (cmd_t, stat_t).
module mcif_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  mcif_pkg::stat_t st,
  output mcif_pkg::cmd_t  cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic state;
  logic state_next;
  logic stall;

  assign in_ready = (state == S_IDLE);
  // hold the scan while a result is due and the output register is still full
  assign stall    = st.emit_here && !st.out_free;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        cmd.load = in_valid;
        if (in_valid) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.step = !stall;
        cmd.emit = !stall && st.emit_here;
        if (!stall && st.scan_last) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> rtl/core/mcif_dpath.sv
// Datapath of the interval finder: config, channel state, start times,
// channel scan index and output register. Depends on mcif_pkg.
module mcif_dpath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [mcif_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mcif_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_func,
  input  logic [mcif_pkg::TIME_W-1:0]         in_time,
  input  logic [mcif_pkg::STORE_N-1:0]        in_bits,
  input  mcif_pkg::cmd_t                      cmd,
  output mcif_pkg::stat_t                     st,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [mcif_pkg::CH_W-1:0]           out_channel,
  output logic [mcif_pkg::TIME_W-1:0]         out_start,
  output logic [mcif_pkg::TIME_W-1:0]         out_end,
  output logic                                out_last
);

  logic [mcif_pkg::MODE_W-1:0]  compare_mode;
  logic                         compare_value;
  logic [mcif_pkg::STORE_N-1:0] open_flags;
  logic [mcif_pkg::STORE_N-1:0] open_set;
  logic [mcif_pkg::STORE_N-1:0] emit_mask;
  logic [mcif_pkg::TIME_W-1:0]  start_times [mcif_pkg::STORE_N];
  logic [mcif_pkg::TIME_W-1:0]  previous_time;
  logic                         have_previous;
  logic                         func_r;
  logic [mcif_pkg::TIME_W-1:0]  now_r;
  logic [mcif_pkg::TIME_W-1:0]  end_val;
  logic [mcif_pkg::TIME_W-1:0]  open_val;
  logic [mcif_pkg::CH_W-1:0]    idx;

  logic [mcif_pkg::STORE_N-1:0] cond;
  logic [mcif_pkg::TIME_W:0]    mid_sum;
  logic [mcif_pkg::TIME_W-1:0]  mid;
  logic [mcif_pkg::STORE_N:0]   rest_mask;

  assign cond    = mcif_pkg::cond_vec(compare_mode, compare_value, in_bits) & mcif_pkg::CH_MASK;
  assign mid_sum = {1'b0, previous_time} + {1'b0, in_time};
  assign mid     = mid_sum[mcif_pkg::TIME_W:1];
  // channels above the current one that still have a result to give
  assign rest_mask = ({1'b0, emit_mask} >> idx) >> 1;

  assign st.emit_here = emit_mask[idx];
  assign st.scan_last = (idx == mcif_pkg::CH_W'(mcif_pkg::NCH - 1));
  assign st.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      compare_mode  <= mcif_pkg::MODE_RESET;
      compare_value <= mcif_pkg::VALUE_RESET;
      open_flags    <= '0;
      previous_time <= '0;
      have_previous <= 1'b0;
      idx           <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          mcif_pkg::CFG_COMPARE_MODE:  compare_mode  <= cfg_data;
          mcif_pkg::CFG_COMPARE_VALUE: compare_value <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.load) begin
        idx <= '0;
        if (in_func) begin
          open_flags <= '0;
        end else begin
          open_flags <= cond;
        end
      end
      if (cmd.step) begin
        idx <= idx + 1'b1;
        if (st.scan_last) begin
          previous_time <= func_r ? '0 : now_r;
          have_previous <= !func_r;
        end
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r   <= in_func;
      now_r    <= in_time;
      end_val  <= in_func ? previous_time : mid;
      open_val <= have_previous ? mid : in_time;
      if (in_func) begin
        emit_mask <= open_flags;
        open_set  <= '0;
      end else begin
        emit_mask <= open_flags & ~cond;
        open_set  <= cond & ~open_flags;
      end
    end
    if (cmd.step && open_set[idx]) begin
      start_times[idx] <= open_val;
    end
    if (cmd.emit) begin
      out_channel <= idx;
      out_start   <= start_times[idx];
      out_end     <= end_val;
      out_last    <= (rest_mask == '0);
    end
  end

endmodule

>>> rtl/core/multichannel_condition_interval_finder.sv
// Top level of the multichannel condition interval finder.
// Depends on mcif_pkg, mcif_in_if, mcif_out_if, mcif_ctrl, mcif_dpath.
//
//  channel   direction  payload                                   handshake
//  in_ch     sink       func, sample_time, channel_bits           valid/ready
//  out_ch    source     channel, open_time, close_time, last      valid/ready
//  cfg       write      cfg_index selects register, cfg_data      cfg_we
//
// An item is accepted while the controller is idle; the datapath then scans
// its channels one at a time, and the input stays blocked until the scan ends.
// Each result waits in the output register; the scan holds while a result is
// due and that register is still occupied, so a stalled sink adds its stall.
// Synchronous reset clears open intervals, history and config to defaults.
module multichannel_condition_interval_finder (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [mcif_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mcif_pkg::CFG_DATA_W-1:0]  cfg_data,
  mcif_in_if.sink                          in_ch,
  mcif_out_if.source                       out_ch
);

  mcif_pkg::cmd_t  cmd;
  mcif_pkg::stat_t st;

  mcif_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .st       (st),
    .cmd      (cmd)
  );

  mcif_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_func     (in_ch.func),
    .in_time     (in_ch.sample_time),
    .in_bits     (in_ch.channel_bits),
    .cmd         (cmd),
    .st          (st),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_channel (out_ch.channel),
    .out_start   (out_ch.open_time),
    .out_end     (out_ch.close_time),
    .out_last    (out_ch.last)
  );

endmodule

>>> rtl/core/mcif_checker.sv
// Port-level checks of the interval finder, bound to the top level.
// Depends on mcif_pkg and multichannel_condition_interval_finder_assert.svh.
`include "multichannel_condition_interval_finder_assert.svh"

module mcif_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [mcif_pkg::CH_W-1:0]   out_channel,
  input logic                        out_last
);

  // a stalled result stays offered
  `MCIF_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  // a stalled result keeps its channel
  `MCIF_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && !out_ready, $stable(out_channel))
  // an accepted item blocks the input while its channels are scanned
  `MCIF_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)
  // between items only the final result of an item can be waiting
  `MCIF_ASSERT_NOW(a_idle_only_last, clk, rst, in_ready && out_valid, out_last)
  // reset empties the output register
  `MCIF_ASSERT_ALWAYS_NEXT(a_reset_empty, clk, rst, !out_valid)

endmodule

bind multichannel_condition_interval_finder mcif_checker u_mcif_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_channel (out_ch.channel),
  .out_last    (out_ch.last)
);

>>> tb/tb_top.sv
// Testbench of the multichannel condition interval finder: a directed table, then random
// samples and flushes under several compare settings, checked against a predictor or pinned rows.
// Depends on mcif_pkg, mcif_in_if, mcif_out_if and the finder's top level.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mcif_pkg::*;

  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_FLUSH  = 1'b1;
  localparam logic [MODE_W-1:0] MODE_UNUSED_6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_UNUSED_7 = 3'd7;

  localparam int SETTLE_CYCLES = 48;
  localparam int STALL_LIMIT   = 2000;
  localparam int HOLD_CYCLES   = 400;
  localparam int RANDOM_PHASES = 6;
  localparam int DIRECTED_N    = 28;

  typedef struct packed {
    logic [CH_W-1:0]   channel;
    logic [TIME_W-1:0] open_time;
    logic [TIME_W-1:0] close_time;
    logic              last;
  } interval_t;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

  // One directed step: a register write or an item, optionally with its result pinned (one interval or none).
  typedef struct packed {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   reg_idx;
    logic [CFG_DATA_W-1:0]  reg_data;
    logic                   func;
    logic [TIME_W-1:0]      stamp;
    logic [STORE_N-1:0]     bits;
    logic                   pinned;
    logic                   one_result;
    logic [CH_W-1:0]        ch;
    logic [TIME_W-1:0]      st;
    logic [TIME_W-1:0]      en;
  } step_row_t;

  localparam step_row_t DIRECTED_ROWS [DIRECTED_N] = '{
    '{ROW_ITEM, '0, '0, FUNC_FLUSH,  32'd0,         16'h0000, 1'b1, 1'b0, '0, '0, '0},
    '{ROW_ITEM, '0, '0, FUNC_SAMPLE, 32'd100,       16'hFFFF, 1'b1, 1'b0, '0, '0, '0},
    '{ROW_ITEM, '0, '0, FUNC_SAMPLE, 32'd201,       16'hFFFE, 1'b1, 1'b1, 4'd0, 32'd100,
      32'd150},
    '{ROW_ITEM, '0, '0, FUNC_SAMPLE, 32'hFFFF_FFFF, 16'h7FFE, 1'b1, 1'b1, 4'd15, 32'd100,
      32'h8000_0064},
    '{ROW_ITEM, '0, '0, FUNC_SAMPLE, 32'hFFFF_FFFF, 16'h0000, 1'b0, 1'b0, '0, '0, '0},
    '{ROW_ITEM, '0, '0, FUNC_FLUSH,  32'd0,         16'h0000, 1'b1, 1'b0, '0, '0, '0},
    '{ROW_ITEM, '0, '0, FUNC_FLUSH,  32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b0, '0, '0, '0},
    '{ROW_ITEM, '0, '0, FUNC_SAMPLE, 32'd0,         16'hFFFF, 1'b1, 1'b0, '0, '0, '0},
    '{ROW_ITEM, '0, '0, FUNC_SAMPLE, 32'd1000,      16'hAAAA, 1'b0, 1'b0, '0, '0, '0},
    '{ROW_ITEM, '0, '0, FUNC_SAMPLE, 32'd10,        16'h5555, 1'b0, 1'b0, '0, '0, '0},
    '{ROW_ITEM, '0, '0, FUNC_FLUSH,  32'd0,         16'h0000, 1'b0, 1'b0, '0, '0, '0},
    '{ROW_REG,  CFG_COMPARE_MODE,  MODE_NE, '0, '0, '0, 1'b0, 1'b0, '0, '0, '0},
    '{ROW_REG,  CFG_COMPARE_VALUE, 3'd0,    '0, '0, '0, 1'b0, 1'b0, '0, '0, '0},
    '{ROW_ITEM, '0, '0, FUNC_SAMPLE, 32'd20,        16'h0F0F, 1'b1, 1'b0, '0, '0, '0},
    '{ROW_REG,  CFG_COMPARE_MODE,  MODE_UNUSED_7, '0, '0, '0, 1'b0, 1'b0, '0, '0, '0},
    '{ROW_ITEM, '0, '0, FUNC_SAMPLE, 32'd30,        16'hFFFF, 1'b0, 1'b0, '0, '0, '0},
    '{ROW_REG,  CFG_COMPARE_MODE,  MODE_LT, '0, '0, '0, 1'b0, 1'b0, '0, '0, '0},
    '{ROW_REG,  CFG_COMPARE_VALUE, 3'd1,    '0, '0, '0, 1'b0, 1'b0, '0, '0, '0},
    '{ROW_ITEM, '0, '0, FUNC_SAMPLE, 32'd40,        16'h0000, 1'b1, 1'b0, '0, '0, '0},
    '{ROW_REG,  CFG_COMPARE_MODE,  MODE_GE, '0, '0, '0, 1'b0, 1'b0, '0, '0, '0},
    '{ROW_ITEM, '0, '0, FUNC_SAMPLE, 32'd50,        16'h00FF, 1'b0, 1'b0, '0, '0, '0},
    '{ROW_REG,  CFG_COMPARE_MODE,  MODE_GT, '0, '0, '0, 1'b0, 1'b0, '0, '0, '0},
    '{ROW_REG,  CFG_COMPARE_VALUE, 3'd0,    '0, '0, '0, 1'b0, 1'b0, '0, '0, '0},
    '{ROW_ITEM, '0, '0, FUNC_SAMPLE, 32'd60,        16'h000F, 1'b0, 1'b0, '0, '0, '0},
    '{ROW_REG,  CFG_COMPARE_MODE,  MODE_LE, '0, '0, '0, 1'b0, 1'b0, '0, '0, '0},
    '{ROW_REG,  CFG_COMPARE_VALUE, 3'd1,    '0, '0, '0, 1'b0, 1'b0, '0, '0, '0},
    '{ROW_ITEM, '0, '0, FUNC_SAMPLE, 32'd70,        16'h1234, 1'b0, 1'b0, '0, '0, '0},
    '{ROW_ITEM, '0, '0, FUNC_FLUSH,  32'd0,         16'h0000, 1'b0, 1'b0, '0, '0, '0}
  };

  localparam logic [MODE_W-1:0] PHASE_MODE [RANDOM_PHASES] =
    '{MODE_LT, MODE_UNUSED_6, MODE_GE, MODE_EQ, MODE_UNUSED_7, MODE_NE};
  localparam logic PHASE_VALUE [RANDOM_PHASES] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0};
  localparam int PHASE_ITEMS [RANDOM_PHASES] = '{64, 16, 64, 64, 16, 64};

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  mcif_in_if  in_ch ();
  mcif_out_if out_ch ();

  multichannel_condition_interval_finder DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Predictor state and its copy of the registers
  logic [STORE_N-1:0] open_mask;
  logic [TIME_W-1:0]  open_start [STORE_N];
  logic [TIME_W-1:0]  prev_stamp;
  logic               have_prev;
  logic [MODE_W-1:0]  cur_mode;
  logic               cur_value;

  interval_t   expected_intervals [$];
  int unsigned mismatches;
  int unsigned quiet_cycles;
  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  bit          hold_req;
  bit          fed;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [TIME_W-1:0] half_way(input logic [TIME_W-1:0] a,
                                                 input logic [TIME_W-1:0] b);
    logic [TIME_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[TIME_W:1];
  endfunction

  function automatic logic channel_holds(input logic b);
    case (cur_mode)
      MODE_LT: return b < cur_value;
      MODE_LE: return b <= cur_value;
      MODE_EQ: return b == cur_value;
      MODE_NE: return b != cur_value;
      MODE_GT: return b > cur_value;
      MODE_GE: return b >= cur_value;
      default: return 1'b0;
    endcase
  endfunction

  // Advance the predictor by one item; queue the intervals it closes when keep is set.
  function automatic void predict_intervals(input logic f, input logic [TIME_W-1:0] stamp,
                                            input logic [STORE_N-1:0] bits, input logic keep);
    interval_t found [$];
    logic      hit;
    if (f == FUNC_FLUSH) begin
      for (int j = 0; j < NCH; j++) begin
        if (open_mask[j])
          found.insert(found.size(),
                       interval_t'{CH_W'(j), open_start[j], prev_stamp, 1'b0});
      end
      open_mask  = '0;
      prev_stamp = '0;
      have_prev  = 1'b0;
    end else begin
      for (int j = 0; j < NCH; j++) begin
        hit = channel_holds(bits[j]);
        if (hit && !open_mask[j]) begin
          open_mask[j]  = 1'b1;
          open_start[j] = have_prev ? half_way(prev_stamp, stamp) : stamp;
        end else if (!hit && open_mask[j]) begin
          open_mask[j] = 1'b0;
          found.insert(found.size(), interval_t'{CH_W'(j), open_start[j],
                                                 half_way(prev_stamp, stamp), 1'b0});
        end
      end
      prev_stamp = stamp;
      have_prev  = 1'b1;
    end
    if (found.size() > 0) found[found.size() - 1].last = 1'b1;
    if (keep) begin
      foreach (found[k]) expected_intervals.insert(expected_intervals.size(), found[k]);
    end
  endfunction

  // Offer one item after a random gap; return at the edge that accepts it.
  task automatic send_item(input logic f, input logic [TIME_W-1:0] stamp,
                           input logic [STORE_N-1:0] bits);
    int gap;
    gap = 0;
    while (gap < 12 && $urandom_range(0, 99) < src_idle_pct) gap++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.func         <= f;
    in_ch.sample_time  <= stamp;
    in_ch.channel_bits <= bits;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    fed = 1'b1;
  endtask

  // Drop valid, let every queued interval arrive, then cover items that close nothing.
  task automatic wait_idle();
    if (!fed) return;
    in_ch.valid <= 1'b0;
    while (expected_intervals.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    fed = 1'b0;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CFG_COMPARE_MODE) cur_mode = data;
    else cur_value = data[0];
  endtask

  initial begin : stimulus
    step_row_t          row;
    logic               f;
    logic [TIME_W-1:0]  t;
    logic [STORE_N-1:0] b;
    logic [TIME_W-1:0]  stamp_now;
    logic [STORE_N-1:0] level;
    logic [MODE_W-1:0]  mode;
    int unsigned        pick;
    int                 item_no;

    rst                <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_index          <= '0;
    cfg_data           <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.func         <= FUNC_SAMPLE;
    in_ch.sample_time  <= '0;
    in_ch.channel_bits <= '0;
    open_mask  = '0;
    prev_stamp = '0;
    have_prev  = 1'b0;
    cur_mode   = MODE_RESET;
    cur_value  = VALUE_RESET;
    foreach (open_start[j]) open_start[j] = '0;
    mismatches   = 0;
    src_idle_pct = 26;
    snk_idle_pct = 73;
    hold_req     = 1'b0;
    fed          = 1'b0;
    stamp_now    = '0;
    level        = '0;
    item_no      = 0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIRECTED_N; i++) begin
      row = DIRECTED_ROWS[i];
      if (row.kind == ROW_REG) begin
        wait_idle();
        write_reg(row.reg_idx, row.reg_data);
      end else begin
        send_item(row.func, row.stamp, row.bits);
        predict_intervals(row.func, row.stamp, row.bits, !row.pinned);
        if (row.pinned && row.one_result)
          expected_intervals.insert(expected_intervals.size(),
                                    interval_t'{row.ch, row.st, row.en, 1'b1});
      end
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_idle();
      mode = (p == 3) ? MODE_W'($urandom_range(0, 7)) : PHASE_MODE[p];
      write_reg(CFG_COMPARE_MODE, mode);
      write_reg(CFG_COMPARE_VALUE, {2'($urandom_range(0, 3)), PHASE_VALUE[p]});
      // Stall the sink for a long stretch while items keep coming
      if (p == 0) begin
        hold_req = 1'b1;
        level    = STORE_N'($urandom);
      end
      for (int k = 0; k < PHASE_ITEMS[p]; k++) begin
        if (item_no < 96) begin
          src_idle_pct = 26;
          snk_idle_pct = 73;
        end else if (item_no < 192) begin
          src_idle_pct = 73;
          snk_idle_pct = 26;
        end else begin
          src_idle_pct = 0;
          snk_idle_pct = 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 7) begin
          f = FUNC_FLUSH;
          t = $urandom;
          b = STORE_N'($urandom);
        end else begin
          f = FUNC_SAMPLE;
          pick = $urandom_range(0, 99);
          if (pick < 78) stamp_now = stamp_now + $urandom_range(0, 600);
          else if (pick < 88) stamp_now = $urandom;
          else if (pick < 94) stamp_now = stamp_now - $urandom_range(0, 40);
          else stamp_now = 32'hFFFF_FFFF - $urandom_range(0, 300);
          // Mostly flip a few channels so intervals span several samples
          pick = $urandom_range(0, 99);
          if (pick < 70) level = level ^ STORE_N'($urandom & $urandom & $urandom);
          else if (pick < 88) level = STORE_N'($urandom);
          else level = {STORE_N{pick[0]}};
          t = stamp_now;
          b = level;
        end
        send_item(f, t, b);
        predict_intervals(f, t, b, 1'b1);
        item_no++;
      end
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : sink
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      out_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
      @(posedge clk);
    end
  end

  always @(posedge clk) begin : check_intervals
    interval_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_intervals.size() == 0) begin
        $display("%0t: unexpected interval, expected none, got ch %0d start %0d end %0d",
                 $time, out_ch.channel, out_ch.open_time, out_ch.close_time);
        mismatches++;
      end else begin
        want = expected_intervals.pop_front();
        if (out_ch.channel !== want.channel) begin
          $display("%0t: channel expected %0d, got %0d", $time, want.channel, out_ch.channel);
          mismatches++;
        end
        if (out_ch.open_time !== want.open_time) begin
          $display("%0t: open_time expected %0d, got %0d", $time, want.open_time,
                   out_ch.open_time);
          mismatches++;
        end
        if (out_ch.close_time !== want.close_time) begin
          $display("%0t: close_time expected %0d, got %0d", $time, want.close_time,
                   out_ch.close_time);
          mismatches++;
        end
        if (out_ch.last !== want.last) begin
          $display("%0t: last expected %0b, got %0b", $time, want.last, out_ch.last);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || cfg_we || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
      $display("TB_ERROR");
      $finish;
    end
  end

  initial quiet_cycles = 0;

endmodule
